// ===== sv/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// Depends on nothing; the word unit and the allocator import it.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int BLOCK_BYTES = 4096;
	localparam int MAX_BLOCKS  = 65536;
	localparam int WORD_BITS   = 32;

	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 32;
	localparam int CNT_W       = 17;
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int BIDX_W      = ADDR_W - BLOCK_SHIFT;
	localparam int CNTR_W      = LEN_W + 1 - BLOCK_SHIFT;
	localparam int END_W       = CNTR_W + 1;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W      = $clog2(MAP_WORDS);
	localparam int DELTA_W     = $clog2(WORD_BITS + 1);

	localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};
	localparam logic [CNT_W-1:0]     LIM_MAX   = CNT_W'(MAX_BLOCKS);
	localparam logic [WIDX_W-1:0]    LAST_WORD = WIDX_W'(MAP_WORDS - 1);
	localparam logic [BIT_W-1:0]     TOP_BIT   = BIT_W'(WORD_BITS - 1);

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

	typedef enum logic [1:0] {
		REQ_ALLOC       = 2'd0,
		REQ_FREE        = 2'd1,
		REQ_RESERVE     = 2'd2,
		REQ_FREE_REGION = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		OP_COUNT = 2'd0,
		OP_SET   = 2'd1,
		OP_CLR   = 2'd2,
		OP_ALLOC = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_BOUND,
		ST_RD,
		ST_MOD,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] new_word;
		logic [DELTA_W-1:0]   delta;
		logic                 found;
		logic [BIT_W-1:0]     bit_idx;
	} word_res_t;

endpackage

// ===== sv/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the usage bitmap words.
`timescale 1ns / 1ps

module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/bpa_word_unit.sv =====
// Shared per-word unit: applies one map operation to a masked bitmap word.
// Depends on bpa_pkg for op codes and the result struct.
`timescale 1ns / 1ps

module bpa_word_unit import bpa_pkg::*; (
	input  op_t                  op,
	input  logic [WORD_BITS-1:0] word,
	input  logic [WORD_BITS-1:0] mask,
	output word_res_t            res
);

	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] used_bits;
	logic [WORD_BITS-1:0] lowest;
	logic [BIT_W-1:0]     idx;

	assign free_bits = mask & ~word;
	assign used_bits = mask & word;
	// isolate the lowest free bit
	assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
	end

	always_comb begin
		res.found   = 1'b0;
		res.bit_idx = idx;
		case (op)
			OP_COUNT: begin
				res.new_word = word;
				res.delta    = DELTA_W'($countones(free_bits));
			end
			OP_SET: begin
				res.new_word = word | mask;
				res.delta    = DELTA_W'($countones(free_bits));
			end
			OP_CLR: begin
				res.new_word = word & ~mask;
				res.delta    = DELTA_W'($countones(used_bits));
			end
			OP_ALLOC: begin
				res.found    = |free_bits;
				res.new_word = word | lowest;
				res.delta    = DELTA_W'(|free_bits);
			end
			default: begin
				res.new_word = word;
				res.delta    = '0;
			end
		endcase
	end

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// Bitmap page allocator, first fit. Each request passes a prepare and a bound state, then
// a read-modify-write of each bitmap word visited (map RAM through the shared word unit),
// then the result state. One item at a time; busy stays high through the result strobe.
// Reset: asynchronous; then a clearing pass writes all ones into every map word (busy
// high). A total_blocks write starts a recount of the tracked words, with busy high.
// The result strobe lasts one cycle; no receiver stall.
`timescale 1ns / 1ps

module bitmap_page_allocator import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              total_blocks_we,
	input  logic [CNT_W-1:0]  total_blocks,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [LEN_W-1:0]  byte_length,
	output logic              done,
	output logic              status,
	output logic [ADDR_W-1:0] block_address,
	output logic [CNT_W-1:0]  free_blocks,
	output logic [CNT_W-1:0]  used_blocks
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  lim_q;
	logic [CNT_W-1:0]  free_q;
	op_t               op_q;
	logic [BIDX_W-1:0] first_q;
	logic [CNTR_W-1:0] cnt_q;
	logic [END_W-1:0]  end_q;
	logic [CNT_W-1:0]  endm1_q;
	logic [WIDX_W-1:0] w_q;
	logic              status_q;
	logic [ADDR_W-1:0] addr_q;

	logic              accept;
	logic [CNTR_W-1:0] in_cnt;
	logic [LEN_W:0]    len_up;
	logic [CNT_W-1:0]  end_clamp;
	logic              range_ok;
	logic [WIDX_W-1:0] first_w;
	logic [WIDX_W-1:0] last_w;
	logic [BIT_W-1:0]  lo_bit;
	logic [BIT_W-1:0]  hi_bit;
	logic [WORD_BITS-1:0] mask;
	logic              walk_end;

	logic                 ram_we;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WORD_BITS-1:0] ram_rdata;
	word_res_t            res;

	assign accept = start && !busy;

	// block count of the request; round-up done one bit wider so it cannot wrap
	assign len_up = {1'b0, byte_length} + (LEN_W + 1)'(BLOCK_BYTES - 1);
	always_comb begin
		case (req_type)
			REQ_FREE:        in_cnt = CNTR_W'(1);
			REQ_RESERVE:     in_cnt = len_up[LEN_W:BLOCK_SHIFT];
			REQ_FREE_REGION: in_cnt = CNTR_W'(byte_length[LEN_W-1:BLOCK_SHIFT]);
			default:         in_cnt = '0;
		endcase
	end

	// clamp the region end to the tracked total
	assign end_clamp = (end_q > END_W'(lim_q)) ? lim_q : end_q[CNT_W-1:0];
	assign range_ok  = END_W'(first_q) < END_W'(end_clamp);

	// word walk bounds; first_q is known to be below the total once the walk runs
	assign first_w  = first_q[BIT_W +: WIDX_W];
	assign last_w   = endm1_q[BIT_W +: WIDX_W];
	assign lo_bit   = (w_q == first_w) ? first_q[BIT_W-1:0] : '0;
	assign hi_bit   = (w_q == last_w) ? endm1_q[BIT_W-1:0] : TOP_BIT;
	assign mask     = (WORD_FULL << lo_bit) & (WORD_FULL >> (TOP_BIT - hi_bit));
	assign walk_end = (w_q == last_w) || res.found;

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (w_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (w_q),
		.rdata (ram_rdata)
	);

	bpa_word_unit u_unit (
		.op   (op_q),
		.word (ram_rdata),
		.mask (mask),
		.res  (res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (w_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (total_blocks_we || start) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:  state_d = ST_BOUND;
			ST_BOUND: begin
				if (range_ok) begin
					state_d = ST_RD;
				end else if (op_q == OP_COUNT) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RD:    state_d = ST_MOD;
			ST_MOD: begin
				if (!walk_end) begin
					state_d = ST_RD;
				end else if (op_q == OP_COUNT) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RESP:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
		// a new total restarts the recount; during the clearing pass the map is all ones
		if (total_blocks_we && state_q != ST_CLEAR) begin
			state_d = ST_PREP;
		end
	end

	// state outputs
	always_comb begin
		busy      = (state_q != ST_IDLE) || total_blocks_we;
		done      = (state_q == ST_RESP);
		ram_re    = (state_q == ST_RD);
		ram_we    = (state_q == ST_CLEAR) || (state_q == ST_MOD && op_q != OP_COUNT);
		ram_wdata = (state_q == ST_CLEAR) ? WORD_FULL : res.new_word;
	end

	assign status        = status_q;
	assign block_address = addr_q;
	assign free_blocks   = free_q;
	assign used_blocks   = lim_q - free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			w_q      <= '0;
			lim_q    <= '0;
			free_q   <= '0;
			op_q     <= OP_COUNT;
			status_q <= STATUS_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: begin
					w_q <= w_q + WIDX_W'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						// allocate scans from block zero
						first_q  <= (req_type == REQ_ALLOC) ? '0 :
								byte_address[ADDR_W-1:BLOCK_SHIFT];
						cnt_q    <= in_cnt;
						addr_q   <= '0;
						status_q <= (req_type == REQ_ALLOC) ? STATUS_OOM : STATUS_OK;
						case (req_type)
							REQ_ALLOC:   op_q <= OP_ALLOC;
							REQ_RESERVE: op_q <= OP_SET;
							default:     op_q <= OP_CLR;
						endcase
					end
				end
				ST_PREP: begin
					if (op_q == OP_COUNT || op_q == OP_ALLOC) begin
						end_q <= END_W'(lim_q);
					end else begin
						end_q <= END_W'(first_q) + END_W'(cnt_q);
					end
				end
				ST_BOUND: begin
					endm1_q <= end_clamp - CNT_W'(1);
					w_q     <= first_w;
				end
				ST_MOD: begin
					if (op_q == OP_SET || op_q == OP_ALLOC) begin
						free_q <= free_q - CNT_W'(res.delta);
					end else begin
						free_q <= free_q + CNT_W'(res.delta);
					end
					if (op_q == OP_ALLOC && res.found) begin
						status_q <= STATUS_OK;
						addr_q   <= ADDR_W'({w_q, res.bit_idx, {BLOCK_SHIFT{1'b0}}});
					end
					w_q <= w_q + WIDX_W'(1);
				end
				default: begin
				end
			endcase
			// new total: clamp, then (outside the clearing pass) recount the clear bits below it from word zero
			if (total_blocks_we) begin
				lim_q   <= (total_blocks > LIM_MAX) ? LIM_MAX : total_blocks;
				free_q  <= '0;
				if (state_q != ST_CLEAR) begin
					op_q    <= OP_COUNT;
					first_q <= '0;
				end
			end
		end
	end

endmodule
